/* rtl/four_pole_ladder_lowpass_top_assert.svh */
// Assertion macros for the ladder filter.
// The first form checks an implication in the same cycle, the second in the next cycle.
`ifndef FOUR_POLE_LADDER_LOWPASS_TOP_ASSERT_SVH
`define FOUR_POLE_LADDER_LOWPASS_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define FPLL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ladder filter check failed");
`define FPLL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ladder filter check failed");
`else
`define FPLL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FPLL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/fpll_pkg.sv */
package fpll_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int STATE_W     = 24;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int STATE_FRAC  = STATE_W - 4;
    localparam int SAMPLE_FRAC = SAMPLE_W - 1;
    localparam int COEF_FRAC   = 16;
    localparam int GAIN_SHIFT  = SAMPLE_FRAC + COEF_FRAC - STATE_FRAC;
    localparam int OUT_SHIFT   = STATE_FRAC - SAMPLE_FRAC;

    // coefficient widths (all unsigned Q.16 but decay)
    localparam int CF_W    = 17;
    localparam int FB_W    = 20;
    localparam int DECAY_W = 18;

    // shared digit-serial multiplier
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 6;
    localparam int CNT_W      = $clog2(NUM_DIGITS);
    localparam int OPA_W      = 25;
    localparam int OPB_W      = DIGIT_W * NUM_DIGITS;
    localparam int HI_W       = OPA_W + DIGIT_W + 1;
    localparam int PROD_W     = HI_W + OPB_W - COEF_FRAC;
    localparam int SUM_W      = 40;

    localparam logic [FB_W-1:0]    K_CUT      = 20'd76022;
    localparam logic [FB_W-1:0]    K_RES      = 20'd1003445;
    localparam logic [FB_W-1:0]    K_FB_CURVE = 20'd9830;
    localparam logic [FB_W-1:0]    K_DRIVE    = 20'd22946;
    localparam logic [FB_W-1:0]    K_PREV     = 20'd19661;
    localparam logic [DECAY_W-1:0] COEF_ONE   = 18'h10000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RES  = 2'd2;

    // coefficient sequence steps
    localparam logic [3:0] OPC_CUT   = 4'd0;
    localparam logic [3:0] OPC_F2    = 4'd1;
    localparam logic [3:0] OPC_CURVE = 4'd2;
    localparam logic [3:0] OPC_RES   = 4'd3;
    localparam logic [3:0] OPC_FB    = 4'd4;
    localparam logic [3:0] OPC_F4    = 4'd5;
    localparam logic [3:0] OPC_DRIVE = 4'd6;

    // sample sequence steps; steps from OPR_STAGE0 on alternate between the
    // previous-input term (odd) and the decay term (even) of each pole
    localparam logic [3:0] OPR_GAIN   = 4'd0;
    localparam logic [3:0] OPR_FB     = 4'd1;
    localparam logic [3:0] OPR_DRIVE  = 4'd2;
    localparam logic [3:0] OPR_STAGE0 = 4'd3;
    localparam logic [3:0] OPR_LAST   = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COEF,
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef enum logic {
        RND_Q16,
        RND_GAIN
    } rnd_t;

    typedef struct packed {
        logic start;
        rnd_t rnd;
    } mul_ctl_t;

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [STATE_W-1:0] r;
        hi = SUM_W'((2 ** (STATE_W - 1)) - 1);
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            r = hi[STATE_W-1:0];
        end else if (v < lo) begin
            r = lo[STATE_W-1:0];
        end else begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/fpll_mul.sv */
module fpll_mul (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  fpll_pkg::mul_ctl_t                   ctl,
    input  logic signed [fpll_pkg::OPA_W-1:0]    a_in,
    input  logic signed [fpll_pkg::OPB_W-1:0]    b_in,
    output logic                                 done,
    output logic signed [fpll_pkg::PROD_W-1:0]   result
);
    import fpll_pkg::*;

    logic signed [OPA_W-1:0]  a_reg, a_next;
    logic signed [OPB_W-1:0]  b_reg, b_next;
    logic signed [HI_W-1:0]   hi_reg, hi_next;
    logic [OPB_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     run_reg, run_next;
    logic                     fin_reg, fin_next;
    logic                     done_reg, done_next;
    rnd_t                     rnd_reg, rnd_next;
    logic signed [PROD_W-1:0] result_reg, result_next;

    logic                     last;
    logic signed [DIGIT_W:0]  digit;
    logic signed [HI_W-1:0]   pp;
    logic signed [HI_W-1:0]   sum;
    logic signed [PROD_W-1:0] q16;
    logic signed [PROD_W-1:0] qgain;

    // top digit of the multiplier carries the sign
    assign last  = (cnt_reg == CNT_W'(NUM_DIGITS - 1));
    assign digit = last ? $signed({b_reg[DIGIT_W-1], b_reg[DIGIT_W-1:0]})
                        : $signed({1'b0, b_reg[DIGIT_W-1:0]});
    assign pp    = a_reg * digit;
    assign sum   = hi_reg + pp;

    // round half up: drop fraction bits, add back the first dropped bit
    assign q16   = $signed({hi_reg, lo_reg[OPB_W-1:COEF_FRAC]})
                 + $signed({{(PROD_W-1){1'b0}}, lo_reg[COEF_FRAC-1]});
    assign qgain = $signed({hi_reg[PROD_W-(OPB_W-GAIN_SHIFT)-1:0], lo_reg[OPB_W-1:GAIN_SHIFT]})
                 + $signed({{(PROD_W-1){1'b0}}, lo_reg[GAIN_SHIFT-1]});

    always_comb begin
        a_next      = a_reg;
        b_next      = b_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        cnt_next    = cnt_reg;
        run_next    = run_reg;
        rnd_next    = rnd_reg;
        fin_next    = 1'b0;
        done_next   = fin_reg;
        result_next = result_reg;
        if (ctl.start) begin
            a_next   = a_in;
            b_next   = b_in;
            hi_next  = '0;
            lo_next  = '0;
            cnt_next = '0;
            rnd_next = ctl.rnd;
            run_next = 1'b1;
        end else if (run_reg) begin
            hi_next  = sum >>> DIGIT_W;
            lo_next  = {sum[DIGIT_W-1:0], lo_reg[OPB_W-1:DIGIT_W]};
            b_next   = b_reg >>> DIGIT_W;
            cnt_next = cnt_reg + CNT_W'(1);
            if (last) begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end
        if (fin_reg) begin
            result_next = (rnd_reg == RND_GAIN) ? qgain : q16;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= RND_Q16;
        end else begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            rnd_reg  <= rnd_next;
        end
        a_reg      <= a_next;
        b_reg      <= b_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/four_pole_ladder_lowpass_top.sv */
// Resonant four-pole ladder low-pass filter, one 16-bit sample in, one out. All
// multiplies run on one shared multiplier that eats the coefficient four bits per
// cycle. A sample needs 11 multiplies (gain, feedback, drive, two per pole), so
// s_tready stays low until they are done and the result has moved to the output
// register. A finished sample sits in the output register, so the next beat can
// be taken while it waits. Any register write recomputes the coefficients
// (7 multiplies) with s_tready low; the same pass runs once after reset.
// Registers: 0 input gain, 1 cutoff, 2 resonance, each an unsigned Q0.16
// fraction; write only while no sample is in flight.
`include "four_pole_ladder_lowpass_top_assert.svh"

module four_pole_ladder_lowpass_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fpll_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fpll_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fpll_pkg::SAMPLE_W-1:0]     s_tdata,   // [15:0] sample_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fpll_pkg::SAMPLE_W-1:0]     m_tdata    // [15:0] sample_out
);
    import fpll_pkg::*;

    state_t state_reg, state_next;
    logic [3:0] op_reg, op_next;
    logic       pend_reg, pend_next;
    logic       dirty_reg, dirty_next;
    logic       m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0] out_reg, out_next;

    logic [CFG_W-1:0] gain_reg, gain_next;
    logic [CFG_W-1:0] cut_reg, cut_next;
    logic [CFG_W-1:0] res_reg, res_next;

    logic [CF_W-1:0]            f_reg, f_next;
    logic [CF_W-1:0]            f2_reg, f2_next;
    logic [CF_W-1:0]            shape_reg, shape_next;
    logic [FB_W-1:0]            fb_reg, fb_next;
    logic [CF_W-1:0]            drive_reg, drive_next;
    logic signed [DECAY_W-1:0]  decay_reg, decay_next;

    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic signed [STATE_W-1:0]  x_reg, x_next;
    logic signed [STATE_W-1:0]  tmp_reg, tmp_next;
    logic signed [STATE_W-1:0]  si_reg [4];
    logic signed [STATE_W-1:0]  si_next [4];
    logic signed [STATE_W-1:0]  so_reg [4];
    logic signed [STATE_W-1:0]  so_next [4];

    mul_ctl_t                   mul_ctl;
    logic signed [OPA_W-1:0]    mul_a;
    logic signed [OPB_W-1:0]    mul_b;
    logic                       mul_done;
    logic signed [PROD_W-1:0]   mul_res;

    logic                       accept;
    logic                       out_free;
    logic signed [STATE_W-1:0]  y;
    logic signed [STATE_W-OUT_SHIFT:0] o_wide;
    logic signed [STATE_W-OUT_SHIFT:0] o_max;
    logic signed [STATE_W-OUT_SHIFT:0] o_min;
    logic [SAMPLE_W-1:0]        o_sat;

    fpll_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mul_ctl),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (dirty_reg) begin
                    state_next = ST_COEF;
                end else if (s_tvalid) begin
                    state_next = ST_RUN;
                end
            end
            ST_COEF: begin
                if (mul_done && op_reg == OPC_DRIVE) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RUN: begin
                if (mul_done && op_reg == OPR_LAST) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready      = 1'b0;
        mul_ctl.start = 1'b0;
        mul_ctl.rnd   = RND_Q16;
        case (state_reg)
            ST_IDLE: s_tready = !dirty_reg;
            ST_COEF: mul_ctl.start = !pend_reg;
            ST_RUN: begin
                mul_ctl.start = !pend_reg;
                if (op_reg == OPR_GAIN) begin
                    mul_ctl.rnd = RND_GAIN;
                end
            end
            ST_DRAIN: s_tready = 1'b0;
            default: s_tready = 1'b0;
        endcase
    end

    // multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_COEF) begin
            case (op_reg)
                OPC_CUT: begin
                    mul_a = OPA_W'(K_CUT);
                    mul_b = OPB_W'(cut_reg);
                end
                OPC_F2: begin
                    mul_a = OPA_W'(f_reg);
                    mul_b = OPB_W'(f_reg);
                end
                OPC_CURVE: begin
                    mul_a = OPA_W'(K_FB_CURVE);
                    mul_b = OPB_W'(f2_reg);
                end
                OPC_RES: begin
                    mul_a = OPA_W'(K_RES);
                    mul_b = OPB_W'(res_reg);
                end
                OPC_FB: begin
                    mul_a = OPA_W'(fb_reg);
                    mul_b = OPB_W'(shape_reg);
                end
                OPC_F4: begin
                    mul_a = OPA_W'(f2_reg);
                    mul_b = OPB_W'(f2_reg);
                end
                OPC_DRIVE: begin
                    mul_a = OPA_W'(K_DRIVE);
                    mul_b = OPB_W'(drive_reg);
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end else if (state_reg == ST_RUN) begin
            case (op_reg)
                OPR_GAIN: begin
                    mul_a = OPA_W'(sample_reg);
                    mul_b = OPB_W'(gain_reg);
                end
                OPR_FB: begin
                    mul_a = OPA_W'(so_reg[3]);
                    mul_b = OPB_W'(fb_reg);
                end
                OPR_DRIVE: begin
                    mul_a = OPA_W'(x_reg);
                    mul_b = OPB_W'(drive_reg);
                end
                default: begin
                    // current pole always sits at the head of the stage lines
                    if (op_reg[0]) begin
                        mul_a = OPA_W'(si_reg[0]);
                        mul_b = OPB_W'(K_PREV);
                    end else begin
                        mul_a = OPA_W'(so_reg[0]);
                        mul_b = OPB_W'(decay_reg);
                    end
                end
            endcase
        end
    end

    // output rounding and saturation from the last pole's output
    assign o_wide = $signed(x_reg[STATE_W-1:OUT_SHIFT])
                  + $signed({1'b0, x_reg[OUT_SHIFT-1]});
    assign o_max  = (STATE_W-OUT_SHIFT+1)'((2 ** (SAMPLE_W - 1)) - 1);
    assign o_min  = -o_max - (STATE_W-OUT_SHIFT+1)'(1);

    always_comb begin
        if (o_wide > o_max) begin
            o_sat = o_max[SAMPLE_W-1:0];
        end else if (o_wide < o_min) begin
            o_sat = o_min[SAMPLE_W-1:0];
        end else begin
            o_sat = o_wide[SAMPLE_W-1:0];
        end
    end

    assign y = sat_state(SUM_W'(x_reg) + SUM_W'(tmp_reg) + SUM_W'(mul_res));

    // datapath and sequencing
    always_comb begin
        op_next      = op_reg;
        pend_next    = pend_reg;
        dirty_next   = dirty_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        gain_next    = gain_reg;
        cut_next     = cut_reg;
        res_next     = res_reg;
        f_next       = f_reg;
        f2_next      = f2_reg;
        shape_next   = shape_reg;
        fb_next      = fb_reg;
        drive_next   = drive_reg;
        decay_next   = decay_reg;
        sample_next  = sample_reg;
        x_next       = x_reg;
        tmp_next     = tmp_reg;
        for (int i = 0; i < 4; i++) begin
            si_next[i] = si_reg[i];
            so_next[i] = so_reg[i];
        end

        if (state_reg == ST_IDLE) begin
            op_next   = '0;
            pend_next = 1'b0;
            if (dirty_reg) begin
                dirty_next = 1'b0;
            end
        end
        if (mul_ctl.start) begin
            pend_next = 1'b1;
        end
        if (mul_done) begin
            pend_next = 1'b0;
            op_next   = op_reg + 4'd1;
        end

        if (cfg_wr_en) begin
            dirty_next = 1'b1;
            case (cfg_index)
                REG_GAIN: gain_next = cfg_wdata;
                REG_CUT:  cut_next  = cfg_wdata;
                REG_RES:  res_next  = cfg_wdata;
                default:  gain_next = gain_reg;
            endcase
        end

        if (accept) begin
            sample_next = s_tdata;
        end

        if (mul_done && state_reg == ST_COEF) begin
            case (op_reg)
                OPC_CUT: begin
                    f_next     = mul_res[CF_W-1:0];
                    decay_next = $signed(COEF_ONE) - $signed({1'b0, mul_res[CF_W-1:0]});
                end
                OPC_F2:    f2_next    = mul_res[CF_W-1:0];
                OPC_CURVE: shape_next = COEF_ONE[CF_W-1:0] - mul_res[CF_W-1:0];
                OPC_RES:   fb_next    = mul_res[FB_W-1:0];
                OPC_FB:    fb_next    = mul_res[FB_W-1:0];
                OPC_F4:    drive_next = mul_res[CF_W-1:0];
                OPC_DRIVE: drive_next = mul_res[CF_W-1:0];
                default:   f_next     = f_reg;
            endcase
        end

        if (mul_done && state_reg == ST_RUN) begin
            case (op_reg)
                OPR_GAIN:  x_next = sat_state(SUM_W'(mul_res));
                OPR_FB:    x_next = sat_state(SUM_W'(x_reg) - SUM_W'(mul_res));
                OPR_DRIVE: x_next = sat_state(SUM_W'(mul_res));
                default: begin
                    if (op_reg[0]) begin
                        tmp_next = mul_res[STATE_W-1:0];
                    end else begin
                        // pole done: rotate stage lines so the next pole is at the head
                        for (int i = 0; i < 3; i++) begin
                            si_next[i] = si_reg[i+1];
                            so_next[i] = so_reg[i+1];
                        end
                        si_next[3] = x_reg;
                        so_next[3] = y;
                        x_next     = y;
                    end
                end
            endcase
        end

        if (state_reg == ST_DRAIN && out_free) begin
            m_valid_next = 1'b1;
            out_next     = o_sat;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= '0;
            pend_reg    <= 1'b0;
            dirty_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
            gain_reg    <= '0;
            cut_reg     <= '0;
            res_reg     <= '0;
            for (int i = 0; i < 4; i++) begin
                si_reg[i] <= '0;
                so_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            pend_reg    <= pend_next;
            dirty_reg   <= dirty_next;
            m_valid_reg <= m_valid_next;
            gain_reg    <= gain_next;
            cut_reg     <= cut_next;
            res_reg     <= res_next;
            for (int i = 0; i < 4; i++) begin
                si_reg[i] <= si_next[i];
                so_reg[i] <= so_next[i];
            end
        end
        out_reg    <= out_next;
        f_reg      <= f_next;
        f2_reg     <= f2_next;
        shape_reg  <= shape_next;
        fb_reg     <= fb_next;
        drive_reg  <= drive_next;
        decay_reg  <= decay_next;
        sample_reg <= sample_next;
        x_reg      <= x_next;
        tmp_reg    <= tmp_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    `FPLL_ASSERT_NEXT(a_accept_starts_run, aclk, aresetn, accept, state_reg == ST_RUN)
    `FPLL_ASSERT_NOW(a_mul_done_in_seq, aclk, aresetn, mul_done, state_reg == ST_COEF || state_reg == ST_RUN)
    `FPLL_ASSERT_NOW(a_run_op_bound, aclk, aresetn, state_reg == ST_RUN, op_reg <= OPR_LAST)
    `FPLL_ASSERT_NEXT(a_cfg_blocks_input, aclk, aresetn, cfg_wr_en, !s_tready)

endmodule

/* test/tb.sv */
module tb;
    import fpll_pkg::*;

    localparam int  HALF_PERIOD  = 2;
    localparam int  CYCLE_LIMIT  = 1_000_000;
    localparam int  DRAIN_CYCLES = 120;
    localparam int  SEGMENTS     = 8;
    localparam int  SEG_ITEMS    = 131;

    // unused register index: writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // filter constants, unsigned Q.16
    localparam longint CUT_SCALE  = 76022;
    localparam longint RES_SCALE  = 1003445;
    localparam longint FB_BEND    = 9830;
    localparam longint DRIVE_GAIN = 22946;
    localparam longint PREV_TAP   = 19661;
    localparam longint UNITY_Q16  = 65536;

    typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [15:0]            value;     // register value or sample_in
        bit                     fixed;     // output known without the predictor
        logic [15:0]            fixed_out;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;

    int          error_count = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    logic [15:0] pending_outputs [$];

    // predictor copy of registers and ladder state
    int     cfg_gain = 0;
    int     cfg_cutoff = 0;
    int     cfg_res = 0;
    longint pole_x_prev [4];
    longint pole_y_prev [4];

    dir_row_t directed_rows [22] = '{
        '{ROW_SAMPLE, REG_GAIN,  16'h7FFF, 1'b1, 16'h0000},
        '{ROW_SAMPLE, REG_GAIN,  16'h8000, 1'b1, 16'h0000},
        '{ROW_WRITE,  REG_GAIN,  16'hFFFF, 1'b0, 16'h0000},
        // cutoff still zero: drive is zero, stages stay at zero
        '{ROW_SAMPLE, REG_GAIN,  16'h7FFF, 1'b1, 16'h0000},
        '{ROW_WRITE,  REG_CUT,   16'hFFFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_GAIN,  16'h7FFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_GAIN,  16'h7FFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_GAIN,  16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_GAIN,  16'h8000, 1'b0, 16'h0000},
        '{ROW_WRITE,  REG_RES,   16'hFFFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_GAIN,  16'h7FFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_GAIN,  16'h7FFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_GAIN,  16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_GAIN,  16'h0000, 1'b0, 16'h0000},
        // zero cutoff with loaded stages: drive is zero and decay is unity
        '{ROW_WRITE,  REG_CUT,   16'h0000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_GAIN,  16'h1234, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_GAIN,  16'h8000, 1'b0, 16'h0000},
        '{ROW_WRITE,  REG_SPARE, 16'hFFFF, 1'b0, 16'h0000},
        '{ROW_WRITE,  REG_GAIN,  16'h0001, 1'b0, 16'h0000},
        '{ROW_WRITE,  REG_CUT,   16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_GAIN,  16'h5555, 1'b0, 16'h0000},
        '{ROW_SAMPLE, REG_GAIN,  16'hAAAA, 1'b0, 16'h0000}
    };

    // per-segment register settings; -1 picks a random value
    int seg_gain [SEGMENTS] = '{65535, 65535, -1, 0,     -1, 65535, -1, 32768};
    int seg_cut  [SEGMENTS] = '{32768, 65535, -1, 16384, -1, 0,     -1, 1};
    int seg_res  [SEGMENTS] = '{0,     65535, -1, 32768, -1, 65535, -1, -1};

    four_pole_ladder_lowpass_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic longint round_drop(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, int width);
        longint hi;
        hi = (longint'(1) <<< (width - 1)) - 1;
        if (v > hi) begin
            return hi;
        end else if (v < -hi - 1) begin
            return -hi - 1;
        end
        return v;
    endfunction

    function automatic longint umul16(longint a, longint b);
        return (a * b + 32768) >>> 16;
    endfunction

    // one sample through the ladder; updates the predictor's pole state
    function automatic logic [15:0] ladder_step(logic [15:0] smp);
        longint f, f2, shape, fb, drive, decay, x, y, o;
        f     = umul16(cfg_cutoff, CUT_SCALE);
        f2    = umul16(f, f);
        shape = UNITY_Q16 - umul16(FB_BEND, f2);
        fb    = umul16(umul16(cfg_res, RES_SCALE), shape);
        drive = umul16(DRIVE_GAIN, umul16(f2, f2));
        decay = UNITY_Q16 - f;

        x = clip(round_drop(longint'($signed(smp)) * cfg_gain,
                            SAMPLE_FRAC + COEF_FRAC - STATE_FRAC), STATE_W);
        x = clip(x - round_drop(pole_y_prev[3] * fb, COEF_FRAC), STATE_W);
        x = clip(round_drop(x * drive, COEF_FRAC), STATE_W);
        for (int k = 0; k < 4; k++) begin
            y = x + round_drop(pole_x_prev[k] * PREV_TAP, COEF_FRAC)
                  + round_drop(pole_y_prev[k] * decay, COEF_FRAC);
            y = clip(y, STATE_W);
            pole_x_prev[k] = x;
            pole_y_prev[k] = y;
            x = y;
        end
        o = clip(round_drop(pole_y_prev[3], STATE_FRAC - SAMPLE_FRAC), SAMPLE_W);
        return o[15:0];
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_GAIN: cfg_gain   = int'(val);
            REG_CUT:  cfg_cutoff = int'(val);
            REG_RES:  cfg_res    = int'(val);
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // drop valid and wait until every expected output has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
    endtask

    // valid stays high after the beat, unless a random idle gap is drawn, so a back-to-back beat needs no toggle
    task automatic send_sample(logic [15:0] smp, bit fixed, logic [15:0] fixed_out);
        logic [15:0] predicted;
        s_tdata  <= smp;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predicted = ladder_step(smp);
        pending_outputs.push_back(fixed ? fixed_out : predicted);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge aclk);
        end
    endtask

    function automatic logic [15:0] next_sample(logic [15:0] prev);
        case ($urandom_range(9))
            0, 1, 2, 3: return 16'($urandom);
            4:          return 16'h7FFF;
            5:          return 16'h8000;
            6:          return 16'h0000;
            default:    return prev;   // held level lets the poles settle
        endcase
    endfunction

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outputs.size() == 0) begin
                $error("sample_out: beat with nothing expected, got %0d",
                       $signed(m_tdata));
                error_count++;
            end else begin
                logic [15:0] want;
                want = pending_outputs.pop_front();
                if (m_tdata !== want) begin
                    $error("sample_out: expected %0d, got %0d",
                           $signed(want), $signed(m_tdata));
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        logic [15:0] smp;
        for (int k = 0; k < 4; k++) begin
            pole_x_prev[k] = 0;
            pole_y_prev[k] = 0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                settle();
                write_reg(directed_rows[i].index, directed_rows[i].value);
            end else begin
                send_sample(directed_rows[i].value, directed_rows[i].fixed,
                            directed_rows[i].fixed_out);
            end
        end

        smp = 16'h0000;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            settle();
            tx_idle_pct  = (seg % 4 == 1) ? 77 : (seg % 4 == 3) ? 16 : 0;
            rx_stall_pct = (seg % 4 == 2) ? 77 : (seg % 4 == 3) ? 16 : 0;
            write_reg(REG_GAIN, 16'((seg_gain[seg] < 0) ? $urandom_range(65535)
                                                        : seg_gain[seg]));
            write_reg(REG_CUT,  16'((seg_cut[seg] < 0) ? $urandom_range(65535)
                                                       : seg_cut[seg]));
            write_reg(REG_RES,  16'((seg_res[seg] < 0) ? $urandom_range(65535)
                                                       : seg_res[seg]));
            for (int n = 0; n < SEG_ITEMS; n++) begin
                smp = next_sample(smp);
                send_sample(smp, 1'b0, 16'h0000);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

/* four_pole_ladder_lowpass_top.f */
+incdir+rtl
rtl/fpll_pkg.sv
rtl/fpll_mul.sv
rtl/four_pole_ladder_lowpass_top.sv
test/tb.sv
